@@ hw/rtl/sawtc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sawtc_pkg
// Shared sizes, codes and types of the set-associative write-through cache.
// ----------------------------------------------------------------------------
package sawtc_pkg;

  localparam int NUM_SETS  = 128;
  localparam int NUM_WAYS  = 8;   // Power of two.
  localparam int LINE_SIZE = 64;  // Power of two.
  localparam int ADDR_BITS = 32;

  localparam int OFF_W  = $clog2(LINE_SIZE);
  localparam int SET_W  = $clog2(NUM_SETS);
  localparam int WAY_W  = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
  localparam int TAG_W  = ADDR_BITS - OFF_W - SET_W;
  localparam int DATA_AW = SET_W + WAY_W + OFF_W;
  localparam int DATA_DEPTH = NUM_SETS * (2 ** WAY_W) * LINE_SIZE;

  localparam int FIELD_ADDR_W = 32;
  localparam int BYTE_W = 8;
  localparam int TDATA_W = FIELD_ADDR_W + BYTE_W;

  localparam logic [15:0] LFSR_SEED = 16'hACE1;
  localparam logic [15:0] LFSR_TAPS = 16'hB400;

  localparam logic [1:0] ACT_READ   = 2'd0;
  localparam logic [1:0] ACT_WRITE  = 2'd1;
  localparam logic [1:0] ACT_RESP   = 2'd2;
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  localparam logic [2:0] KIND_RDATA   = 3'd0;
  localparam logic [2:0] KIND_MEMWR   = 3'd1;
  localparam logic [2:0] KIND_LINERD  = 3'd2;
  localparam logic [2:0] KIND_BYTERD  = 3'd3;
  localparam logic [2:0] KIND_BUSY    = 3'd4;

  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_RESP  = 2'd2
  } op_t;

  typedef struct packed {
    op_t                    op;
    logic [ADDR_BITS-1:0]   addr;
    logic [BYTE_W-1:0]      data;
  } item_t;

  typedef struct packed {
    logic [2:0]              kind;
    logic [FIELD_ADDR_W-1:0] mem_address;
    logic [BYTE_W-1:0]       value;
    logic                    last;
  } result_t;

endpackage

@@ hw/rtl/set_assoc_write_through_cache_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// set_assoc_write_through_cache_top
// Byte-wide 8-way write-through cache with random replacement and line fill.
// ----------------------------------------------------------------------------
//   Channel  Ports                  Content
//   in       in_tvalid/in_tready    tuser action, tdata address and data
//   out      out_tvalid/out_tready  tuser kind, tdata address and value, tlast
//
// After reset the valid store of all sets is cleared before a request is
// taken, and requests with the unused action are dropped. A fill byte is
// written from idle; a response byte with a result or a busy reject goes to
// the result state, a write or read miss through the lookup first, and a
// read hit also the data read; a write miss gives a second result.
// A two-entry queue takes requests while the back end stalls, until full.
module set_assoc_write_through_cache_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [sawtc_pkg::TDATA_W-1:0] in_tdata,  // address, data
  input  logic [1:0]                    in_tuser,  // action
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [sawtc_pkg::TDATA_W-1:0] out_tdata, // mem_address, value
  output logic [2:0]                    out_tuser, // kind
  output logic                          out_tlast
);

  logic             q_valid;
  logic             q_ready;
  sawtc_pkg::item_t q_item;

  sawtc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_item    (q_item)
  );

  sawtc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_ready    (q_ready),
    .q_item     (q_item),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

@@ hw/rtl/sawtc_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sawtc_front
// Accepts requests, classifies them and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module sawtc_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [sawtc_pkg::TDATA_W-1:0] in_tdata,
  input  logic [1:0]                    in_tuser,
  output logic                          q_valid,
  input  logic                          q_ready,
  output sawtc_pkg::item_t              q_item
);

  sawtc_pkg::item_t slot_r [2];
  logic             wr_ptr_r, wr_ptr_nxt;
  logic             rd_ptr_r, rd_ptr_nxt;
  logic [1:0]       count_r, count_nxt;
  logic             push, pop, keep;
  sawtc_pkg::item_t item_in;

  always_comb begin
    item_in.addr = in_tdata[sawtc_pkg::ADDR_BITS-1:0];
    item_in.data = in_tdata[sawtc_pkg::TDATA_W-1:sawtc_pkg::FIELD_ADDR_W];
    case (in_tuser)
      sawtc_pkg::ACT_READ:  begin item_in.op = sawtc_pkg::OP_READ;  keep = 1'b1; end
      sawtc_pkg::ACT_WRITE: begin item_in.op = sawtc_pkg::OP_WRITE; keep = 1'b1; end
      sawtc_pkg::ACT_RESP:  begin item_in.op = sawtc_pkg::OP_RESP;  keep = 1'b1; end
      default:              begin item_in.op = sawtc_pkg::OP_READ;  keep = 1'b0; end
    endcase
  end

  assign in_tready = (count_r != 2'd2);
  assign push      = in_tvalid && in_tready && keep;
  assign q_valid   = (count_r != 2'd0);
  assign pop       = q_valid && q_ready;
  assign q_item    = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= item_in;
    end
  end

endmodule

@@ hw/rtl/sawtc_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sawtc_back
// Tag lookup, line fill, miss tracking and result register of the cache.
// ----------------------------------------------------------------------------
module sawtc_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_valid,
  output logic                          q_ready,
  input  sawtc_pkg::item_t              q_item,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [sawtc_pkg::TDATA_W-1:0] out_tdata,
  output logic [2:0]                    out_tuser,
  output logic                          out_tlast
);

  localparam int OFF_W = sawtc_pkg::OFF_W;
  localparam int SET_W = sawtc_pkg::SET_W;
  localparam int WAY_W = sawtc_pkg::WAY_W;
  localparam int TAG_W = sawtc_pkg::TAG_W;
  localparam int NW    = sawtc_pkg::NUM_WAYS;
  localparam int AW    = sawtc_pkg::ADDR_BITS;

  typedef enum logic [5:0] {
    ST_CLEAR = 6'b000001,
    ST_IDLE  = 6'b000010,
    ST_LOOK  = 6'b000100,
    ST_RDATA = 6'b001000,
    ST_EMIT1 = 6'b010000,
    ST_EMIT2 = 6'b100000
  } state_t;

  typedef enum logic [2:0] {
    PH_IDLE = 3'b001,
    PH_FILL = 3'b010,
    PH_BYTE = 3'b100
  } phase_t;

  logic [NW-1:0]       valid_mem [sawtc_pkg::NUM_SETS];
  logic [NW*TAG_W-1:0] tag_mem   [sawtc_pkg::NUM_SETS];
  logic [7:0]          data_mem  [sawtc_pkg::DATA_DEPTH];

  state_t               state_r, state_nxt;
  phase_t               phase_r, phase_nxt;
  logic [SET_W-1:0]     clr_idx_r, clr_idx_nxt;
  logic [OFF_W-1:0]     fill_cnt_r, fill_cnt_nxt;
  logic [15:0]          lfsr_r, lfsr_nxt;
  sawtc_pkg::item_t     item_r, item_nxt;
  logic [SET_W-1:0]     miss_set_r, miss_set_nxt;
  logic [TAG_W-1:0]     miss_tag_r, miss_tag_nxt;
  logic [OFF_W-1:0]     miss_off_r, miss_off_nxt;
  logic [WAY_W-1:0]     miss_way_r, miss_way_nxt;
  logic                 miss_read_r, miss_read_nxt;
  logic [7:0]           miss_byte_r, miss_byte_nxt;
  logic [NW-1:0]        miss_vrow_r, miss_vrow_nxt;
  logic [NW*TAG_W-1:0]  miss_trow_r, miss_trow_nxt;
  sawtc_pkg::result_t   res1_r, res1_nxt, res2_r, res2_nxt;
  logic                 has2_r, has2_nxt;
  sawtc_pkg::result_t   out_r, out_nxt;
  logic                 out_valid_r, out_valid_nxt;

  logic [NW-1:0]        vrow_rd_r;
  logic [NW*TAG_W-1:0]  trow_rd_r;
  logic [7:0]           data_rd_r;

  logic [SET_W-1:0]     lk_set;
  logic [TAG_W-1:0]     lk_tag;
  logic [OFF_W-1:0]     lk_off;
  logic [NW-1:0]        hit_vec;
  logic                 hit;
  logic [WAY_W-1:0]     hit_way;
  logic                 has_free;
  logic [WAY_W-1:0]     free_way;
  logic [15:0]          lfsr_step;
  logic [WAY_W-1:0]     alloc_way;
  logic [NW-1:0]        alloc_bit;
  logic [NW-1:0]        fin_bit;
  logic [NW*TAG_W-1:0]  fin_trow;
  logic [7:0]           fill_byte;
  logic                 can_emit;

  logic                 vwr_en;
  logic [SET_W-1:0]     vwr_set;
  logic [NW-1:0]        vwr_row;
  logic                 twr_en;
  logic                 dwr_en;
  logic [sawtc_pkg::DATA_AW-1:0] dwr_addr;
  logic [7:0]           dwr_data;
  logic                 drd_en;
  logic [sawtc_pkg::DATA_AW-1:0] drd_addr;

  assign lk_off = item_r.addr[OFF_W-1:0];
  assign lk_set = item_r.addr[OFF_W+SET_W-1:OFF_W];
  assign lk_tag = item_r.addr[AW-1:OFF_W+SET_W];
  assign can_emit = !out_valid_r || out_tready;
  assign lfsr_step = lfsr_r[0] ? ((lfsr_r >> 1) ^ sawtc_pkg::LFSR_TAPS) : (lfsr_r >> 1);
  assign fill_byte = (fill_cnt_r == miss_off_r) ? q_item.data : miss_byte_r;

  always_comb begin
    hit      = 1'b0;
    hit_way  = '0;
    has_free = 1'b0;
    free_way = '0;
    for (int w = NW - 1; w >= 0; w--) begin
      hit_vec[w] = vrow_rd_r[w] && (trow_rd_r[w*TAG_W +: TAG_W] == lk_tag);
      if (hit_vec[w]) begin
        hit     = 1'b1;
        hit_way = WAY_W'(w);
      end
      if (!vrow_rd_r[w]) begin
        has_free = 1'b1;
        free_way = WAY_W'(w);
      end
    end
    alloc_way = has_free ? free_way : lfsr_step[WAY_W-1:0];
    for (int w = 0; w < NW; w++) begin
      alloc_bit[w] = (alloc_way == WAY_W'(w));
      fin_bit[w]   = (miss_way_r == WAY_W'(w));
      fin_trow[w*TAG_W +: TAG_W] = fin_bit[w] ? miss_tag_r : miss_trow_r[w*TAG_W +: TAG_W];
    end
  end

  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    clr_idx_nxt   = clr_idx_r;
    fill_cnt_nxt  = fill_cnt_r;
    lfsr_nxt      = lfsr_r;
    item_nxt      = item_r;
    miss_set_nxt  = miss_set_r;
    miss_tag_nxt  = miss_tag_r;
    miss_off_nxt  = miss_off_r;
    miss_way_nxt  = miss_way_r;
    miss_read_nxt = miss_read_r;
    miss_byte_nxt = miss_byte_r;
    miss_vrow_nxt = miss_vrow_r;
    miss_trow_nxt = miss_trow_r;
    res1_nxt      = res1_r;
    res2_nxt      = res2_r;
    has2_nxt      = has2_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_tready;
    q_ready       = 1'b0;
    vwr_en        = 1'b0;
    vwr_set       = clr_idx_r;
    vwr_row       = '0;
    twr_en        = 1'b0;
    dwr_en        = 1'b0;
    dwr_addr      = {lk_set, hit_way, lk_off};
    dwr_data      = item_r.data;
    drd_en        = 1'b0;
    drd_addr      = {lk_set, hit_way, lk_off};

    case (state_r)
      ST_CLEAR: begin
        vwr_en      = 1'b1;
        clr_idx_nxt = clr_idx_r + 1'b1;
        if (clr_idx_r == SET_W'(sawtc_pkg::NUM_SETS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        q_ready = q_valid;
        if (q_valid) begin
          item_nxt = q_item;
          has2_nxt = 1'b0;
          if (q_item.op == sawtc_pkg::OP_RESP) begin
            if (phase_r == PH_BYTE) begin
              phase_nxt = PH_IDLE;
              res1_nxt  = '{sawtc_pkg::KIND_RDATA, '0, q_item.data, 1'b1};
              state_nxt = ST_EMIT1;
            end else if (phase_r == PH_FILL) begin
              dwr_en   = 1'b1;
              dwr_addr = {miss_set_r, miss_way_r, fill_cnt_r};
              dwr_data = q_item.data;
              if (fill_cnt_r == miss_off_r) begin
                miss_byte_nxt = q_item.data;
              end
              fill_cnt_nxt = fill_cnt_r + 1'b1;
              if (fill_cnt_r == '1) begin
                vwr_en    = 1'b1;
                vwr_set   = miss_set_r;
                vwr_row   = miss_vrow_r | fin_bit;
                twr_en    = 1'b1;
                phase_nxt = PH_IDLE;
                if (miss_read_r) begin
                  res1_nxt  = '{sawtc_pkg::KIND_RDATA, '0, fill_byte, 1'b1};
                  state_nxt = ST_EMIT1;
                end
              end
            end
          end else if (phase_r != PH_IDLE) begin
            res1_nxt  = '{sawtc_pkg::KIND_BUSY, '0, '0, 1'b1};
            state_nxt = ST_EMIT1;
          end else begin
            state_nxt = ST_LOOK;
          end
        end
      end
      ST_LOOK: begin
        if (item_r.op == sawtc_pkg::OP_WRITE || !hit) begin
          state_nxt = ST_EMIT1;
        end
        if (item_r.op == sawtc_pkg::OP_WRITE) begin
          res1_nxt = '{sawtc_pkg::KIND_MEMWR, item_r.addr, item_r.data, hit};
          if (hit) begin
            dwr_en = 1'b1;
          end
        end else if (hit) begin
          drd_en    = 1'b1;
          state_nxt = ST_RDATA;
        end
        if (!hit && (item_r.op == sawtc_pkg::OP_WRITE || has_free)) begin
          if (!has_free) begin
            lfsr_nxt = lfsr_step;
          end
          phase_nxt     = PH_FILL;
          fill_cnt_nxt  = '0;
          miss_set_nxt  = lk_set;
          miss_tag_nxt  = lk_tag;
          miss_off_nxt  = lk_off;
          miss_way_nxt  = alloc_way;
          miss_read_nxt = (item_r.op == sawtc_pkg::OP_READ);
          miss_vrow_nxt = vrow_rd_r & ~alloc_bit;
          miss_trow_nxt = trow_rd_r;
          if (item_r.op == sawtc_pkg::OP_WRITE) begin
            has2_nxt = 1'b1;
            res2_nxt = '{sawtc_pkg::KIND_LINERD, {item_r.addr[AW-1:OFF_W], OFF_W'(0)},
                         '0, 1'b1};
          end else begin
            res1_nxt = '{sawtc_pkg::KIND_LINERD, {item_r.addr[AW-1:OFF_W], OFF_W'(0)},
                         '0, 1'b1};
          end
        end else if (!hit) begin
          phase_nxt     = PH_BYTE;
          miss_read_nxt = 1'b1;
          res1_nxt      = '{sawtc_pkg::KIND_BYTERD, item_r.addr, '0, 1'b1};
        end
      end
      ST_RDATA: begin
        res1_nxt  = '{sawtc_pkg::KIND_RDATA, '0, data_rd_r, 1'b1};
        state_nxt = ST_EMIT1;
      end
      ST_EMIT1: begin
        if (can_emit) begin
          out_nxt       = res1_r;
          out_valid_nxt = 1'b1;
          state_nxt     = has2_r ? ST_EMIT2 : ST_IDLE;
        end
      end
      ST_EMIT2: begin
        if (can_emit) begin
          out_nxt       = res2_r;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      phase_r     <= PH_IDLE;
      clr_idx_r   <= '0;
      fill_cnt_r  <= '0;
      lfsr_r      <= sawtc_pkg::LFSR_SEED;
      miss_read_r <= 1'b0;
      has2_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      clr_idx_r   <= clr_idx_nxt;
      fill_cnt_r  <= fill_cnt_nxt;
      lfsr_r      <= lfsr_nxt;
      miss_read_r <= miss_read_nxt;
      has2_r      <= has2_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r      <= item_nxt;
    miss_set_r  <= miss_set_nxt;
    miss_tag_r  <= miss_tag_nxt;
    miss_off_r  <= miss_off_nxt;
    miss_way_r  <= miss_way_nxt;
    miss_byte_r <= miss_byte_nxt;
    miss_vrow_r <= miss_vrow_nxt;
    miss_trow_r <= miss_trow_nxt;
    res1_r      <= res1_nxt;
    res2_r      <= res2_nxt;
    out_r       <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (vwr_en) begin
      valid_mem[vwr_set] <= vwr_row;
    end
    vrow_rd_r <= valid_mem[q_item.addr[OFF_W+SET_W-1:OFF_W]];
  end

  always_ff @(posedge clk) begin
    if (twr_en) begin
      tag_mem[miss_set_r] <= fin_trow;
    end
    trow_rd_r <= tag_mem[q_item.addr[OFF_W+SET_W-1:OFF_W]];
  end

  always_ff @(posedge clk) begin
    if (dwr_en) begin
      data_mem[dwr_addr] <= dwr_data;
    end
    if (drd_en) begin
      data_rd_r <= data_mem[drd_addr];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_r.value, out_r.mem_address};
  assign out_tuser  = out_r.kind;
  assign out_tlast  = out_r.last;

endmodule
